/* design/bbo_pkg.sv */
package bbo_pkg;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_MIN   = 3;
    localparam int DIM_RESET = 256;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    localparam logic [13:0] GRAY_WB    = 14'd1868;
    localparam logic [13:0] GRAY_WG    = 14'd9617;
    localparam logic [13:0] GRAY_WR    = 14'd4899;
    localparam logic [21:0] GRAY_ROUND = 22'd8192;
    localparam int          GRAY_SHIFT = 14;

    localparam int BM_MARK = 0;
    localparam int BM_BIN  = 1;

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
        int x;
        x = int'(v);
        if (x < DIM_MIN)
        begin
            x = DIM_MIN;
        end
        if (x > maxv)
        begin
            x = maxv;
        end
        return x;
    endfunction

endpackage

/* design/bbo_if.sv */
interface bbo_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output opcode, output blue, output green, output red,
                    input ready);
    modport sink (input valid, input opcode, input blue, input green, input red,
                  output ready);
endinterface

interface bbo_out_if;
    logic       valid;
    logic       ready;
    logic       cleared_bit;
    logic       binary_bit;
    logic [7:0] otsu_level;
    logic       last_pixel;

    modport source (output valid, output cleared_bit, output binary_bit, output otsu_level,
                    output last_pixel, input ready);
    modport sink (input valid, input cleared_bit, input binary_bit, input otsu_level,
                  input last_pixel, output ready);
endinterface

/* design/bbo_ram.sv */
module bbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

/* design/bbo_mul.sv */
module bbo_mul #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] prod
);

    logic         busy_reg, busy_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

endmodule

/* design/bbo_otsu.sv */
module bbo_otsu import bbo_pkg::*; #(
    parameter int PW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] total,
    output logic          hist_re,
    output logic [7:0]    hist_addr,
    input  logic [PW-1:0] hist_data,
    output logic          done,
    output logic [7:0]    level
);

    localparam int SW   = PW + 8;
    localparam int AW   = PW + SW;
    localparam int DENW = 2 * PW;
    localparam int LW   = 2 * AW + DENW;

    typedef enum logic [10:0] {
        O_IDLE   = 11'b00000000001,
        O_SUM_RD = 11'b00000000010,
        O_SUM_AC = 11'b00000000100,
        O_RD     = 11'b00000001000,
        O_ACC    = 11'b00000010000,
        O_MA     = 11'b00000100000,
        O_MB     = 11'b00001000000,
        O_MDEN   = 11'b00010000000,
        O_MSQ    = 11'b00100000000,
        O_ML     = 11'b01000000000,
        O_MR     = 11'b10000000000
    } ostate_t;

    ostate_t         state_reg, state_next;
    logic            done_reg, done_next;
    logic [7:0]      idx_reg, idx_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [PW-1:0]   w1_reg, w1_next;
    logic [SW-1:0]   s1_reg, s1_next;
    logic [AW-1:0]   a_reg, a_next;
    logic [AW-1:0]   d_reg, d_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [2*AW-1:0] sq_reg, sq_next;
    logic [LW-1:0]   lhs_reg, lhs_next;
    logic [2*AW-1:0] best_sq_reg, best_sq_next;
    logic [DENW-1:0] best_den_reg, best_den_next;
    logic [7:0]      best_reg, best_next;

    logic            mul_start, mul_done, adv;
    logic [LW-1:0]   mul_a, mul_b, prod;
    logic [PW-1:0]   w1_new;
    logic [SW-1:0]   s1_new, ih;
    logic [AW-1:0]   pb;

    bbo_mul #(.W(LW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign ih     = SW'(idx_reg) * SW'(hist_data);
    assign w1_new = w1_reg + hist_data;
    assign s1_new = s1_reg + ih;
    assign pb     = prod[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        w1_next       = w1_reg;
        s1_next       = s1_reg;
        a_next        = a_reg;
        d_next        = d_reg;
        den_next      = den_reg;
        sq_next       = sq_reg;
        lhs_next      = lhs_reg;
        best_sq_next  = best_sq_reg;
        best_den_next = best_den_reg;
        best_next     = best_reg;
        hist_re       = 1'b0;
        hist_addr     = idx_reg;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        adv           = 1'b0;
        unique case (state_reg)
            O_IDLE:
            begin
                if (start)
                begin
                    idx_next      = '0;
                    sum_next      = '0;
                    best_sq_next  = '0;
                    best_den_next = DENW'(1);
                    best_next     = '0;
                    state_next    = O_SUM_RD;
                end
            end
            O_SUM_RD:
            begin
                hist_re    = 1'b1;
                state_next = O_SUM_AC;
            end
            O_SUM_AC:
            begin
                sum_next = sum_reg + ih;
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'hFF)
                begin
                    w1_next    = '0;
                    s1_next    = '0;
                    state_next = O_RD;
                end
                else
                begin
                    state_next = O_SUM_RD;
                end
            end
            O_RD:
            begin
                hist_re    = 1'b1;
                state_next = O_ACC;
            end
            O_ACC:
            begin
                w1_next = w1_new;
                s1_next = s1_new;
                if (w1_new == '0 || w1_new >= total)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = LW'(total);
                    mul_b      = LW'(s1_new);
                    state_next = O_MA;
                end
            end
            O_MA:
            begin
                if (mul_done)
                begin
                    a_next     = pb;
                    mul_start  = 1'b1;
                    mul_a      = LW'(w1_reg);
                    mul_b      = LW'(sum_reg);
                    state_next = O_MB;
                end
            end
            O_MB:
            begin
                if (mul_done)
                begin
                    d_next     = (a_reg > pb) ? a_reg - pb : pb - a_reg;
                    mul_start  = 1'b1;
                    mul_a      = LW'(w1_reg);
                    mul_b      = LW'(total - w1_reg);
                    state_next = O_MDEN;
                end
            end
            O_MDEN:
            begin
                if (mul_done)
                begin
                    den_next   = prod[DENW-1:0];
                    mul_start  = 1'b1;
                    mul_a      = LW'(d_reg);
                    mul_b      = LW'(d_reg);
                    state_next = O_MSQ;
                end
            end
            O_MSQ:
            begin
                if (mul_done)
                begin
                    sq_next    = prod[2*AW-1:0];
                    mul_start  = 1'b1;
                    mul_a      = LW'(prod[2*AW-1:0]);
                    mul_b      = LW'(best_den_reg);
                    state_next = O_ML;
                end
            end
            O_ML:
            begin
                if (mul_done)
                begin
                    lhs_next   = prod;
                    mul_start  = 1'b1;
                    mul_a      = LW'(best_sq_reg);
                    mul_b      = LW'(den_reg);
                    state_next = O_MR;
                end
            end
            O_MR:
            begin
                if (mul_done)
                begin
                    if (lhs_reg > prod)
                    begin
                        best_sq_next  = sq_reg;
                        best_den_next = den_reg;
                        best_next     = idx_reg;
                    end
                    adv = 1'b1;
                end
            end
            default:
            begin
                state_next = O_IDLE;
            end
        endcase
        if (adv)
        begin
            if (idx_reg == 8'hFF)
            begin
                done_next  = 1'b1;
                state_next = O_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + 8'd1;
                state_next = O_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= O_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        w1_reg       <= w1_next;
        s1_reg       <= s1_next;
        a_reg        <= a_next;
        d_reg        <= d_next;
        den_reg      <= den_next;
        sq_reg       <= sq_next;
        lhs_reg      <= lhs_next;
        best_sq_reg  <= best_sq_next;
        best_den_reg <= best_den_next;
        best_reg     <= best_next;
    end

    assign done  = done_reg;
    assign level = best_reg;

endmodule

/* design/bbo_fill.sv */
module bbo_fill import bbo_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [7:0]                               thr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]           width_px,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]          height_px,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] total,
    output logic                                     gray_re,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  gray_addr,
    input  logic [7:0]                               gray_data,
    output logic                                     bm_re,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  bm_raddr,
    input  logic [1:0]                               bm_rdata,
    output logic                                     bm_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  bm_waddr,
    output logic [1:0]                               bm_wdata,
    output logic                                     done
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW  = $clog2(NPIX);
    localparam int PW   = $clog2(NPIX + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int QW   = XW + YW + PAW;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_INIT  = 6'b000010,
        F_POP   = 6'b000100,
        F_QWAIT = 6'b001000,
        F_NRD   = 6'b010000,
        F_NCHK  = 6'b100000
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic           done_reg, done_next;
    logic [PW-1:0]  p_reg, p_next;
    logic [XW-1:0]  x_reg, x_next;
    logic [YW-1:0]  y_reg, y_next;
    logic           sv_reg, sv_next;
    logic [PAW-1:0] sp_reg, sp_next;
    logic [XW-1:0]  sx_reg, sx_next;
    logic [YW-1:0]  sy_reg, sy_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [XW-1:0]  qx_reg, qx_next;
    logic [YW-1:0]  qy_reg, qy_next;
    logic [PAW-1:0] qi_reg, qi_next;
    logic [1:0]     dx_reg, dx_next;
    logic [1:0]     dy_reg, dy_next;
    logic [PAW-1:0] n_reg, n_next;
    logic [XW-1:0]  nx_reg, nx_next;
    logic [YW-1:0]  ny_reg, ny_next;

    logic           q_we, q_re;
    logic [QW-1:0]  q_wdata, q_rdata;
    logic           s_bin, s_frame, s_mark, nok, step;
    logic [XW-1:0]  wlast, nx_c;
    logic [YW-1:0]  hlast, ny_c;
    logic [PAW+1:0] nrow, n_c;

    bbo_ram #(.WIDTH(QW), .DEPTH(NPIX)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[PAW-1:0]),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg[PAW-1:0]),
        .rdata (q_rdata)
    );

    assign wlast   = XW'(width_px - 1'b1);
    assign hlast   = YW'(height_px - 1'b1);
    assign s_bin   = gray_data > thr;
    assign s_frame = (sx_reg == '0) || (sy_reg == '0) || (sx_reg == wlast) || (sy_reg == hlast);
    assign s_mark  = s_bin && s_frame;

    assign nok = !(dx_reg == 2'd0 && qx_reg == '0) && !(dx_reg == 2'd2 && qx_reg == wlast)
              && !(dy_reg == 2'd0 && qy_reg == '0) && !(dy_reg == 2'd2 && qy_reg == hlast);
    assign nx_c = qx_reg + XW'(dx_reg) - XW'(1);
    assign ny_c = qy_reg + YW'(dy_reg) - YW'(1);

    always_comb
    begin
        unique case (dy_reg)
            2'd0:    nrow = (PAW+2)'(qi_reg) - (PAW+2)'(width_px);
            2'd2:    nrow = (PAW+2)'(qi_reg) + (PAW+2)'(width_px);
            default: nrow = (PAW+2)'(qi_reg);
        endcase
        n_c = nrow + (PAW+2)'(dx_reg) - (PAW+2)'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        p_next     = p_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sv_next    = 1'b0;
        sp_next    = sp_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        qi_next    = qi_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        n_next     = n_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        gray_re    = 1'b0;
        gray_addr  = p_reg[PAW-1:0];
        bm_re      = 1'b0;
        bm_raddr   = n_c[PAW-1:0];
        bm_we      = 1'b0;
        bm_waddr   = sp_reg;
        bm_wdata   = '0;
        q_we       = 1'b0;
        q_re       = 1'b0;
        q_wdata    = {sy_reg, sx_reg, sp_reg};
        step       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    p_next     = '0;
                    x_next     = '0;
                    y_next     = '0;
                    tail_next  = '0;
                    head_next  = '0;
                    state_next = F_INIT;
                end
            end
            F_INIT:
            begin
                if (p_reg != total)
                begin
                    gray_re = 1'b1;
                    sv_next = 1'b1;
                    sp_next = p_reg[PAW-1:0];
                    sx_next = x_reg;
                    sy_next = y_reg;
                    p_next  = p_reg + 1'b1;
                    if (x_reg == wlast)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
                else if (!sv_reg)
                begin
                    state_next = F_POP;
                end
                if (sv_reg)
                begin
                    bm_we              = 1'b1;
                    bm_wdata[BM_BIN]   = s_bin;
                    bm_wdata[BM_MARK]  = s_mark;
                    if (s_mark)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
            end
            F_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    q_re       = 1'b1;
                    head_next  = head_reg + 1'b1;
                    state_next = F_QWAIT;
                end
            end
            F_QWAIT:
            begin
                {qy_next, qx_next, qi_next} = q_rdata;
                dx_next    = '0;
                dy_next    = '0;
                state_next = F_NRD;
            end
            F_NRD:
            begin
                if (nok)
                begin
                    bm_re      = 1'b1;
                    n_next     = n_c[PAW-1:0];
                    nx_next    = nx_c;
                    ny_next    = ny_c;
                    state_next = F_NCHK;
                end
                else
                begin
                    step = 1'b1;
                end
            end
            F_NCHK:
            begin
                if (bm_rdata[BM_BIN] && !bm_rdata[BM_MARK])
                begin
                    bm_we     = 1'b1;
                    bm_waddr  = n_reg;
                    bm_wdata  = 2'b11;
                    q_we      = 1'b1;
                    q_wdata   = {ny_reg, nx_reg, n_reg};
                    tail_next = tail_reg + 1'b1;
                end
                step = 1'b1;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (step)
        begin
            state_next = F_NRD;
            if (dx_reg == 2'd2)
            begin
                dx_next = '0;
                if (dy_reg == 2'd2)
                begin
                    state_next = F_POP;
                end
                else
                begin
                    dy_next = dy_reg + 2'd1;
                end
            end
            else
            begin
                dx_next = dx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            sv_reg    <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            sv_reg    <= sv_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            p_reg     <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        sp_reg <= sp_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qi_reg <= qi_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        n_reg  <= n_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
    end

    assign done = done_reg;

endmodule

/* design/binary_border_object_clearing.sv */
// channel  dir  beat contents
// pix      in   opcode, blue, green, red
// res      out  cleared_bit, binary_bit, otsu_level, last_pixel
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// a load beat does a gray write plus a histogram read-modify-write
// a read result goes via the bitmap read reg to res, held until res is ready
// after the last load: a histogram sum over all 256 bins, then otsu search of
// 256 levels with up to 6 serial multiplies each
// fill: a frame pass at one pixel per cycle, then a 3x3 scan per queued object pixel
// pix.ready stays low during the search, the fill and while a read result waits
// reset clears control only
module binary_border_object_clearing import bbo_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bbo_in_if.sink               pix,
    bbo_out_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW  = $clog2(NPIX);
    localparam int PW   = $clog2(NPIX + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [6:0] {
        T_LOAD  = 7'b0000001,
        T_HIST  = 7'b0000010,
        T_OTSU  = 7'b0000100,
        T_FILL  = 7'b0001000,
        T_READ  = 7'b0010000,
        T_RWAIT = 7'b0100000,
        T_DONE  = 7'b1000000
    } tstate_t;

    tstate_t        state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     g_reg, g_next;
    logic [7:0]     thr_reg, thr_next;
    logic [WW-1:0]  w_reg, w_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [255:0]   hvalid_reg, hvalid_next;
    logic           hv_rd_reg, hv_rd_next;
    logic           last_reg, last_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_clr_reg, out_bin_reg, out_last_reg;
    logic [7:0]     out_lvl_reg;

    logic           pix_acc, restart, out_load, rd_re;
    logic [PW-1:0]  total;
    logic [21:0]    gray_sum;
    logic [7:0]     gray;
    logic           hist_we, hist_re;
    logic [7:0]     hist_raddr;
    logic [PW-1:0]  hist_rdata, hist_data;
    logic           gray_we;
    logic [7:0]     gray_rdata;
    logic           otsu_start, otsu_done, otsu_re;
    logic [7:0]     otsu_addr, otsu_level;
    logic           fill_start, fill_done, fill_gray_re, fill_bm_re, bm_we;
    logic [PAW-1:0] fill_gray_addr, fill_bm_raddr, bm_waddr, bm_raddr;
    logic [1:0]     bm_wdata, bm_rdata;

    assign pix_acc  = pix.valid && pix.ready;
    assign total    = PW'(w_reg) * PW'(h_reg);
    assign gray_sum = 22'(pix.blue) * 22'(GRAY_WB) + 22'(pix.green) * 22'(GRAY_WG)
                    + 22'(pix.red) * 22'(GRAY_WR) + GRAY_ROUND;
    assign gray     = gray_sum[GRAY_SHIFT +: 8];
    assign pix.ready = (state_reg == T_LOAD) || (state_reg == T_READ) || (state_reg == T_DONE);
    assign hist_data = hv_rd_reg ? hist_rdata : '0;

    bbo_ram #(.WIDTH(PW), .DEPTH(256)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (g_reg),
        .wdata (hist_data + 1'b1),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    bbo_ram #(.WIDTH(8), .DEPTH(NPIX)) u_gray (
        .clk   (clk),
        .we    (gray_we),
        .waddr (pos_reg[PAW-1:0]),
        .wdata (gray),
        .re    (fill_gray_re),
        .raddr (fill_gray_addr),
        .rdata (gray_rdata)
    );

    assign bm_raddr = rd_re ? pos_reg[PAW-1:0] : fill_bm_raddr;

    bbo_ram #(.WIDTH(2), .DEPTH(NPIX)) u_bm (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (fill_bm_re || rd_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bbo_otsu #(.PW(PW)) u_otsu (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (otsu_start),
        .total     (total),
        .hist_re   (otsu_re),
        .hist_addr (otsu_addr),
        .hist_data (hist_data),
        .done      (otsu_done),
        .level     (otsu_level)
    );

    bbo_fill #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fill_start),
        .thr       (thr_reg),
        .width_px  (w_reg),
        .height_px (h_reg),
        .total     (total),
        .gray_re   (fill_gray_re),
        .gray_addr (fill_gray_addr),
        .gray_data (gray_rdata),
        .bm_re     (fill_bm_re),
        .bm_raddr  (fill_bm_raddr),
        .bm_rdata  (bm_rdata),
        .bm_we     (bm_we),
        .bm_waddr  (bm_waddr),
        .bm_wdata  (bm_wdata),
        .done      (fill_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        g_next      = g_reg;
        thr_next    = thr_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        hvalid_next = hvalid_reg;
        last_next   = last_reg;
        hist_we     = 1'b0;
        hist_re     = 1'b0;
        hist_raddr  = otsu_addr;
        gray_we     = 1'b0;
        rd_re       = 1'b0;
        otsu_start  = 1'b0;
        fill_start  = 1'b0;
        out_load    = 1'b0;
        restart     = cfg_we || (pix_acc && opcode_t'(pix.opcode) == OP_CLEAR);
        unique case (state_reg)
            T_LOAD:
            begin
                if (pix_acc && opcode_t'(pix.opcode) == OP_LOAD)
                begin
                    gray_we    = 1'b1;
                    hist_re    = 1'b1;
                    hist_raddr = gray;
                    g_next     = gray;
                    state_next = T_HIST;
                end
            end
            T_HIST:
            begin
                hist_we            = 1'b1;
                hvalid_next[g_reg] = 1'b1;
                if (pos_reg == total - 1'b1)
                begin
                    pos_next   = '0;
                    otsu_start = 1'b1;
                    state_next = T_OTSU;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = T_LOAD;
                end
            end
            T_OTSU:
            begin
                hist_re = otsu_re;
                if (otsu_done)
                begin
                    thr_next   = otsu_level;
                    fill_start = 1'b1;
                    state_next = T_FILL;
                end
            end
            T_FILL:
            begin
                if (fill_done)
                begin
                    pos_next   = '0;
                    state_next = T_READ;
                end
            end
            T_READ:
            begin
                if (pix_acc && opcode_t'(pix.opcode) == OP_READ)
                begin
                    rd_re      = 1'b1;
                    last_next  = pos_reg == total - 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    state_next = T_RWAIT;
                end
            end
            T_RWAIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = last_reg ? T_DONE : T_READ;
                end
            end
            T_DONE:
            begin
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  w_next = WW'(clamp_dim(cfg_data, MAX_WIDTH));
                CFG_HEIGHT: h_next = HW'(clamp_dim(cfg_data, MAX_HEIGHT));
                default:
                begin
                end
            endcase
        end
        if (restart)
        begin
            hvalid_next = '0;
            pos_next    = '0;
            thr_next    = '0;
            state_next  = T_LOAD;
        end
        hv_rd_next     = hist_re ? hvalid_reg[hist_raddr] : hv_rd_reg;
        out_valid_next = out_load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_LOAD;
            pos_reg       <= '0;
            thr_reg       <= '0;
            w_reg         <= WW'(clamp_dim(CFG_W'(DIM_RESET), MAX_WIDTH));
            h_reg         <= HW'(clamp_dim(CFG_W'(DIM_RESET), MAX_HEIGHT));
            hvalid_reg    <= '0;
            hv_rd_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            thr_reg       <= thr_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            hvalid_reg    <= hvalid_next;
            hv_rd_reg     <= hv_rd_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        if (out_load)
        begin
            out_clr_reg  <= bm_rdata[BM_BIN] ^ bm_rdata[BM_MARK];
            out_bin_reg  <= bm_rdata[BM_BIN];
            out_lvl_reg  <= thr_reg;
            out_last_reg <= last_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.cleared_bit = out_clr_reg;
    assign res.binary_bit  = out_bin_reg;
    assign res.otsu_level  = out_lvl_reg;
    assign res.last_pixel  = out_last_reg;

endmodule
